### src/itda_pkg.sv
package itda_pkg;

	localparam int BIN_W = 31;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam int ACC_W = BCD_W + BIN_W;
	localparam int STAGE_STEPS = 8;
	localparam int LAST_STEPS = BIN_W - 3 * STAGE_STEPS;
	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef logic [ACC_W-1:0] acc_t;
	typedef logic [3:0] digit_t;

	// shift-add-3 binary to BCD: BCD digits sit above the binary bits
	function automatic acc_t dabble(input acc_t acc, input int steps);
		acc_t a;
		a = acc;
		for (int s = 0; s < STAGE_STEPS; s++) begin
			if (s < steps) begin
				for (int d = 0; d < BCD_DIGITS; d++) begin
					if (a[BIN_W + 4*d +: 4] >= 4'd5) begin
						a[BIN_W + 4*d +: 4] = a[BIN_W + 4*d +: 4] + 4'd3;
					end
				end
				a = a << 1;
			end
		end
		return a;
	endfunction

endpackage

### src/itda_serial.sv
module itda_serial #(
	parameter int LIMIT = 10,
	parameter int IDX_W = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load_valid,
	output logic                            load_ready,
	input  logic [4*LIMIT-1:0]              load_digits,
	input  logic [IDX_W-1:0]                load_top,
	output logic                            digit_valid,
	input  logic                            digit_ready,
	output logic [itda_pkg::CHAR_W-1:0]     digit_char,
	output logic                            last
);

	logic                 busy_q;
	logic [IDX_W-1:0]     idx_q;
	itda_pkg::digit_t     digits_q [LIMIT];
	logic                 out_xfer;
	logic                 load_xfer;

	assign last        = (idx_q == '0);
	assign digit_valid = busy_q;
	assign out_xfer    = busy_q && digit_ready;
	assign load_ready  = !busy_q || (digit_ready && last);
	assign load_xfer   = load_valid && load_ready;
	assign digit_char  = itda_pkg::ASCII_ZERO + {2'b00, digits_q[idx_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load_xfer) begin
			busy_q <= 1'b1;
			idx_q  <= load_top;
		end else if (out_xfer) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_xfer) begin
			for (int i = 0; i < LIMIT; i++) begin
				digits_q[i] <= load_digits[4*i +: 4];
			end
		end
	end

endmodule

### src/int_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
// Input channel: value (31 bits) with value_valid / value_ready. One number
// is taken per transfer.
// Output channel: digit_char (ASCII '0'..'9') and last, with digit_valid /
// digit_ready. Each number yields its digits most significant first, no
// leading zeros; last marks the least significant digit. Numbers with more
// than MAX_DIGITS digits (capped at 10) give their low MAX_DIGITS digits.
// Each number passes through four shift-add-3 stages, one digit count
// stage, then the character serializer.
// Throughput: one character per cycle on the output port while digit_ready
// is high; the serializer is the limit, and the five pipeline stages keep
// up to five more numbers queued behind it.
// Reset clears all valid bits; nothing is in flight afterwards.
// When the receiver stalls, the current character holds and the pipeline
// fills behind it, then drops value_ready; nothing is lost or repeated.
module int_to_decimal_ascii #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            value_valid,
	output logic                            value_ready,
	input  logic [itda_pkg::BIN_W-1:0]      value,
	output logic                            digit_valid,
	input  logic                            digit_ready,
	output logic [itda_pkg::CHAR_W-1:0]     digit_char,
	output logic                            last
);

	localparam int LIMIT = (MAX_DIGITS > itda_pkg::BCD_DIGITS) ? itda_pkg::BCD_DIGITS :
		((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
	localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic ser_ready;
	itda_pkg::acc_t acc_s1, acc_s2, acc_s3, acc_s4;
	logic [4*LIMIT-1:0] digits_s5;
	logic [IDX_W-1:0]   top_s5;
	logic [IDX_W-1:0]   top_d;

	assign rdy5 = !v_s5 || ser_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign value_ready = rdy1;

	// index of the most significant digit to print
	always_comb begin
		top_d = '0;
		for (int i = 0; i < itda_pkg::BCD_DIGITS; i++) begin
			if (acc_s4[itda_pkg::BIN_W + 4*i +: 4] != 4'd0) begin
				top_d = (i >= LIMIT) ? IDX_W'(LIMIT - 1) : IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= value_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && value_valid) begin
			acc_s1 <= itda_pkg::dabble({{itda_pkg::BCD_W{1'b0}}, value},
				itda_pkg::STAGE_STEPS);
		end
		if (rdy2 && v_s1) begin
			acc_s2 <= itda_pkg::dabble(acc_s1, itda_pkg::STAGE_STEPS);
		end
		if (rdy3 && v_s2) begin
			acc_s3 <= itda_pkg::dabble(acc_s2, itda_pkg::STAGE_STEPS);
		end
		if (rdy4 && v_s3) begin
			acc_s4 <= itda_pkg::dabble(acc_s3, itda_pkg::LAST_STEPS);
		end
		if (rdy5 && v_s4) begin
			digits_s5 <= acc_s4[itda_pkg::BIN_W +: 4*LIMIT];
			top_s5    <= top_d;
		end
	end

	itda_serial #(
		.LIMIT (LIMIT),
		.IDX_W (IDX_W)
	) u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (v_s5),
		.load_ready  (ser_ready),
		.load_digits (digits_s5),
		.load_top    (top_s5),
		.digit_valid (digit_valid),
		.digit_ready (digit_ready),
		.digit_char  (digit_char),
		.last        (last)
	);

endmodule
